FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
// Each use stands on a line of its own and carries no trailing semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: hw/rtl/atrb_pkg.sv
// ----------------------------------------------------------------------------
// atrb_pkg
// Types, constants and helper functions for the time reply decoder.
// ----------------------------------------------------------------------------
package atrb_pkg;

  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] INVALID_YEAR = 8'h70;
  localparam logic [7:0] START_CHAR   = 8'h3A;
  localparam logic [7:0] END_CHAR     = 8'h0A;

  // Only the buffer positions that feed a result field are kept.
  localparam int unsigned NUM_SLOTS = 16;

  localparam int unsigned SLOT_WD0     = 0;
  localparam int unsigned SLOT_WD1     = 1;
  localparam int unsigned SLOT_WD2     = 2;
  localparam int unsigned SLOT_MO0     = 3;
  localparam int unsigned SLOT_MO1     = 4;
  localparam int unsigned SLOT_MO2     = 5;
  localparam int unsigned SLOT_DATE_HI = 6;
  localparam int unsigned SLOT_DATE_LO = 7;
  localparam int unsigned SLOT_HOUR_HI = 8;
  localparam int unsigned SLOT_HOUR_LO = 9;
  localparam int unsigned SLOT_MIN_HI  = 10;
  localparam int unsigned SLOT_MIN_LO  = 11;
  localparam int unsigned SLOT_SEC_HI  = 12;
  localparam int unsigned SLOT_SEC_LO  = 13;
  localparam int unsigned SLOT_YEAR_HI = 14;
  localparam int unsigned SLOT_YEAR_LO = 15;

  // Buffer position held by each slot, in slot order.
  localparam logic [5:0] SLOT_POS [NUM_SLOTS] = '{
    6'd1, 6'd2, 6'd3, 6'd5, 6'd6, 6'd7, 6'd9, 6'd10,
    6'd12, 6'd13, 6'd15, 6'd16, 6'd18, 6'd19, 6'd23, 6'd24
  };

  localparam int unsigned NUM_WEEKDAYS = 7;
  localparam int unsigned NUM_MONTHS   = 12;

  localparam logic [23:0] WEEKDAY_NAMES [NUM_WEEKDAYS] = '{
    "Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"
  };

  localparam logic [23:0] MONTH_NAMES [NUM_MONTHS] = '{
    "Jan", "Feb", "Mar", "Apr", "May", "Jun",
    "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
  };

  localparam logic [4:0] MONTH_BCD [NUM_MONTHS] = '{
    5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06,
    5'h07, 5'h08, 5'h09, 5'h10, 5'h11, 5'h12
  };

  // Snapshot of one finished message; unwritten positions are zero.
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] slots;
  } frame_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [7:0] date_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] second_bcd;
    logic [2:0] weekday_bcd;
    logic       month_found;
    logic       weekday_found;
    logic       set_clock;
  } result_t;

  // Both digits are offset with wrapping; the low digit's upper bits can
  // leak into the high nibble.
  function automatic logic [7:0] pair_bcd(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - ASCII_ZERO;
    l = lo - ASCII_ZERO;
    return {h[3:0], 4'b0000} | l;
  endfunction

  // True when the pattern, cut at its first zero byte, occurs inside the name.
  function automatic logic name_match(input logic [23:0] name, input logic [7:0] p0,
                                      input logic [7:0] p1, input logic [7:0] p2);
    logic [7:0] n0;
    logic [7:0] n1;
    logic [7:0] n2;
    logic       hit;
    n0 = name[23:16];
    n1 = name[15:8];
    n2 = name[7:0];
    if (p0 == 8'h00) begin
      hit = 1'b1;
    end else if (p1 == 8'h00) begin
      hit = (p0 == n0) || (p0 == n1) || (p0 == n2);
    end else if (p2 == 8'h00) begin
      hit = ((p0 == n0) && (p1 == n1)) || ((p0 == n1) && (p1 == n2));
    end else begin
      hit = (p0 == n0) && (p1 == n1) && (p2 == n2);
    end
    return hit;
  endfunction

endpackage

FILE: hw/rtl/atrb_capture.sv
// ----------------------------------------------------------------------------
// atrb_capture
// Hunts for the start colon, tracks the write position and keeps the bytes
// of interest. At the end of a message it loads a frame register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atrb_capture import atrb_pkg::*; #(
  parameter int unsigned BUFFER_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       frame_valid_o,
  input  logic       frame_ready_i,
  output frame_t     frame_o
);

  localparam int unsigned IdxW = $clog2(BUFFER_LEN);

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW:0]    idx_inc;
  logic [7:0]       cap_q [NUM_SLOTS];
  logic             frame_valid_q, frame_valid_d;
  frame_t           frame_q, frame_d;
  logic             in_acc;
  logic             store;
  logic             msg_end;

  assign in_stall_o = frame_valid_q && !frame_ready_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Bytes before the colon are dropped.
  assign store   = in_acc && ((idx_q != '0) || (rx_byte_i == START_CHAR));
  assign idx_inc = {1'b0, idx_q} + (IdxW+1)'(1);
  assign msg_end = (rx_byte_i == END_CHAR) || (idx_inc == (IdxW+1)'(BUFFER_LEN));

  always_comb begin
    idx_d = idx_q;
    if (store) begin
      idx_d = msg_end ? '0 : idx_inc[IdxW-1:0];
    end
  end

  // Positions past the current byte were not written in this message.
  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (SLOT_POS[k] == 6'(idx_q)) begin
        frame_d.slots[k] = rx_byte_i;
      end else if (SLOT_POS[k] < 6'(idx_q)) begin
        frame_d.slots[k] = cap_q[k];
      end else begin
        frame_d.slots[k] = 8'h00;
      end
    end
  end

  always_comb begin
    frame_valid_d = frame_valid_q;
    if (store && msg_end) begin
      frame_valid_d = 1'b1;
    end else if (frame_ready_i) begin
      frame_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      idx_q         <= idx_d;
      frame_valid_q <= frame_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (store && (SLOT_POS[k] == 6'(idx_q))) begin
        cap_q[k] <= rx_byte_i;
      end
    end
    if (store && msg_end) begin
      frame_q <= frame_d;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

  `ASSERT_PROP(a_idx_range, clk_i, rst_ni, 32'(idx_q) < BUFFER_LEN, "write index out of range")
  `ASSERT_PROP(a_end_loads_frame, clk_i, rst_ni,
               store && msg_end |=> frame_valid_q && (idx_q == '0),
               "message end did not load frame")
  `ASSERT_PROP(a_frame_hold, clk_i, rst_ni,
               frame_valid_q && !frame_ready_i |=> frame_valid_q && $stable(frame_q),
               "waiting frame changed")

endmodule

FILE: hw/rtl/atrb_decode.sv
// ----------------------------------------------------------------------------
// atrb_decode
// Converts a frame into BCD fields and name indices and holds the result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atrb_decode import atrb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    frame_valid_i,
  output logic    frame_ready_o,
  input  frame_t  frame_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  result_t res;
  result_t result_q;
  logic    out_valid_q, out_valid_d;
  logic    take;

  always_comb begin
    res = '0;
    res.year_bcd   = pair_bcd(frame_i.slots[SLOT_YEAR_HI], frame_i.slots[SLOT_YEAR_LO]);
    res.date_bcd   = pair_bcd(frame_i.slots[SLOT_DATE_HI], frame_i.slots[SLOT_DATE_LO]);
    res.hour_bcd   = pair_bcd(frame_i.slots[SLOT_HOUR_HI], frame_i.slots[SLOT_HOUR_LO]);
    res.minute_bcd = pair_bcd(frame_i.slots[SLOT_MIN_HI], frame_i.slots[SLOT_MIN_LO]);
    res.second_bcd = pair_bcd(frame_i.slots[SLOT_SEC_HI], frame_i.slots[SLOT_SEC_LO]);
    res.set_clock  = (res.year_bcd != INVALID_YEAR);
    // When several names match, the later one in the list wins.
    for (int d = 0; d < NUM_WEEKDAYS; d++) begin
      if (name_match(WEEKDAY_NAMES[d], frame_i.slots[SLOT_WD0], frame_i.slots[SLOT_WD1],
                     frame_i.slots[SLOT_WD2])) begin
        res.weekday_bcd   = 3'(d + 1);
        res.weekday_found = 1'b1;
      end
    end
    for (int d = 0; d < NUM_MONTHS; d++) begin
      if (name_match(MONTH_NAMES[d], frame_i.slots[SLOT_MO0], frame_i.slots[SLOT_MO1],
                     frame_i.slots[SLOT_MO2])) begin
        res.month_bcd   = MONTH_BCD[d];
        res.month_found = 1'b1;
      end
    end
  end

  assign frame_ready_o = !out_valid_q || !out_stall_i;
  assign take          = frame_valid_i && frame_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_ready_o) begin
      out_valid_d = frame_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `ASSERT_PROP(a_take_to_out, clk_i, rst_ni, take |=> out_valid_q, "taken frame did not reach output")
  `ASSERT_NEVER(a_wd_unfound, clk_i, rst_ni,
                out_valid_q && !result_q.weekday_found && (result_q.weekday_bcd != 3'd0),
                "weekday index without match")
  `ASSERT_NEVER(a_mo_found, clk_i, rst_ni,
                out_valid_q && result_q.month_found && (result_q.month_bcd == 5'd0),
                "month match with zero index")

endmodule

FILE: hw/rtl/ascii_time_reply_to_bcd.sv
// ----------------------------------------------------------------------------
// ascii_time_reply_to_bcd
// Collects a serial time reply starting at a colon and decodes it into
// BCD date and time fields with weekday and month indices.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                 payload
//   in        in          in_valid_i / in_stall_o   rx_byte_i
//   out       out         out_valid_o / out_stall_i year .. set_clock
//
// One byte is accepted per cycle while in_stall_o is low. A result is held
// in the frame register and then in the output register. Reset clears the
// write position and both valid flags. in_stall_o rises only while a
// finished frame waits behind a stalled output register.
// ----------------------------------------------------------------------------
module ascii_time_reply_to_bcd import atrb_pkg::*; #(
  parameter int unsigned BUFFER_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] year_bcd_o,
  output logic [4:0] month_bcd_o,
  output logic [7:0] date_bcd_o,
  output logic [7:0] hour_bcd_o,
  output logic [7:0] minute_bcd_o,
  output logic [7:0] second_bcd_o,
  output logic [2:0] weekday_bcd_o,
  output logic       month_found_o,
  output logic       weekday_found_o,
  output logic       set_clock_o
);

  logic    frame_valid;
  logic    frame_ready;
  frame_t  frame;
  result_t result;

  atrb_capture #(
    .BUFFER_LEN (BUFFER_LEN)
  ) u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  atrb_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_o      (result)
  );

  assign year_bcd_o      = result.year_bcd;
  assign month_bcd_o     = result.month_bcd;
  assign date_bcd_o      = result.date_bcd;
  assign hour_bcd_o      = result.hour_bcd;
  assign minute_bcd_o    = result.minute_bcd;
  assign second_bcd_o    = result.second_bcd;
  assign weekday_bcd_o   = result.weekday_bcd;
  assign month_found_o   = result.month_found;
  assign weekday_found_o = result.weekday_found;
  assign set_clock_o     = result.set_clock;

endmodule

FILE: verif/ascii_time_reply_to_bcd_tb.sv
// ----------------------------------------------------------------------------
// ascii_time_reply_to_bcd_tb
// Feeds serial bytes into the time reply decoder: noise, well-formed replies
// with random names and digits, short replies and replies that overrun the
// buffer. A byte-level model predicts every decoded reply, and each reply
// that leaves the block is checked field by field.
// ----------------------------------------------------------------------------
module ascii_time_reply_to_bcd_tb import atrb_pkg::*; ();

  localparam int unsigned BUF_LEN     = 32;
  localparam int unsigned PLAN_BYTES  = 1000;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 8;

  localparam logic [7:0] COLON_CHAR   = 8'h3A;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] NO_SET_YEAR  = 8'h70;

  localparam int STALL_NONE  = 0;
  localparam int STALL_SOME  = 1;
  localparam int STALL_HEAVY = 2;

  typedef struct packed {
    logic [7:0] value;
    logic       drain;
  } rx_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] year_bcd_o;
  logic [4:0] month_bcd_o;
  logic [7:0] date_bcd_o;
  logic [7:0] hour_bcd_o;
  logic [7:0] minute_bcd_o;
  logic [7:0] second_bcd_o;
  logic [2:0] weekday_bcd_o;
  logic       month_found_o;
  logic       weekday_found_o;
  logic       set_clock_o;

  // Decoder model state.
  logic [7:0] cap_buf [BUF_LEN];
  logic [5:0] cap_pos;

  rx_item_t byte_plan [$];
  result_t  pending_replies [$];

  int mismatches = 0;
  int bytes_taken = 0;
  int replies_seen = 0;
  int weekday_hits = 0;
  int month_hits = 0;
  int clock_kept = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit held_long = 1'b0;
  int seg_left = 0;
  int seg_mode = STALL_NONE;
  int quiet_cycles = 0;

  ascii_time_reply_to_bcd dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .year_bcd_o     (year_bcd_o),
    .month_bcd_o    (month_bcd_o),
    .date_bcd_o     (date_bcd_o),
    .hour_bcd_o     (hour_bcd_o),
    .minute_bcd_o   (minute_bcd_o),
    .second_bcd_o   (second_bcd_o),
    .weekday_bcd_o  (weekday_bcd_o),
    .month_found_o  (month_found_o),
    .weekday_found_o(weekday_found_o),
    .set_clock_o    (set_clock_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [23:0] day_abbr(input int d);
    case (d)
      0: return "Mon";
      1: return "Tue";
      2: return "Wed";
      3: return "Thu";
      4: return "Fri";
      5: return "Sat";
      default: return "Sun";
    endcase
  endfunction

  function automatic logic [23:0] month_abbr(input int m);
    case (m)
      0: return "Jan";
      1: return "Feb";
      2: return "Mar";
      3: return "Apr";
      4: return "May";
      5: return "Jun";
      6: return "Jul";
      7: return "Aug";
      8: return "Sep";
      9: return "Oct";
      10: return "Nov";
      default: return "Dec";
    endcase
  endfunction

  // The pattern stops at its first zero byte and may sit at any offset.
  function automatic bit abbr_holds(input logic [23:0] name, input logic [23:0] pat);
    int len;
    bit ok;
    len = 0;
    while (len < 3 && pat[23-8*len -: 8] != 8'h00) len++;
    for (int off = 0; off + len <= 3; off++) begin
      ok = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (name[23-8*(off+k) -: 8] != pat[23-8*k -: 8]) ok = 1'b0;
      end
      if (ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Both offsets wrap at 8 bits, so the low digit can spill into the high nibble.
  function automatic logic [7:0] digits_to_bcd(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - DIGIT_ZERO;
    l = lo - DIGIT_ZERO;
    return {h[3:0], 4'h0} | l;
  endfunction

  // Advances the model by one byte; returns 1 when a reply is decoded.
  function automatic bit take_byte(input logic [7:0] b, output result_t r);
    logic [23:0] day_pat;
    logic [23:0] mon_pat;
    int          m;
    r = '0;
    if (b != COLON_CHAR && cap_pos == 6'd0) return 1'b0;
    cap_buf[cap_pos] = b;
    cap_pos = cap_pos + 6'd1;
    if (b != NEWLINE_CHAR && cap_pos < BUF_LEN && cap_pos != 6'd0) return 1'b0;
    cap_pos = 6'd0;
    r.year_bcd   = digits_to_bcd(cap_buf[23], cap_buf[24]);
    r.date_bcd   = digits_to_bcd(cap_buf[9], cap_buf[10]);
    r.hour_bcd   = digits_to_bcd(cap_buf[12], cap_buf[13]);
    r.minute_bcd = digits_to_bcd(cap_buf[15], cap_buf[16]);
    r.second_bcd = digits_to_bcd(cap_buf[18], cap_buf[19]);
    day_pat = {cap_buf[1], cap_buf[2], cap_buf[3]};
    mon_pat = {cap_buf[5], cap_buf[6], cap_buf[7]};
    // Later names overwrite earlier ones, so the last match wins.
    for (int d = 0; d < 7; d++) begin
      if (abbr_holds(day_abbr(d), day_pat)) begin
        r.weekday_bcd   = 3'(d + 1);
        r.weekday_found = 1'b1;
      end
    end
    for (int d = 0; d < 12; d++) begin
      if (abbr_holds(month_abbr(d), mon_pat)) begin
        m = d + 1;
        r.month_bcd   = 5'(((m / 10) << 4) | (m % 10));
        r.month_found = 1'b1;
      end
    end
    r.set_clock = (r.year_bcd != NO_SET_YEAR);
    for (int i = 0; i < BUF_LEN; i++) cap_buf[i] = 8'h00;
    return 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit drain = 1'b0);
    byte_plan.push_back('{value: b, drain: drain});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rnd_digit();
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return DIGIT_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly real names; the rest are fragments cut by zero bytes or junk.
  function automatic logic [23:0] rnd_name(input bit is_month);
    logic [23:0] name;
    int          off;
    name = is_month ? month_abbr($urandom_range(0, 11)) : day_abbr($urandom_range(0, 6));
    off  = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      6: return {8'($urandom_range(32, 126)), 8'($urandom_range(32, 126)),
                 8'($urandom_range(32, 126))};
      7: return {name[23-8*off -: 8], 16'h0000};
      8: return {name[23-8*(off%2) -: 16], 8'h00};
      9: return 24'h000000;
      default: return name;
    endcase
  endfunction

  task automatic push_random_reply(input bit drain);
    logic [7:0]  msg [$];
    logic [23:0] name;
    logic [7:0]  b;
    int          cut;
    repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
    msg.push_back(COLON_CHAR);
    name = rnd_name(1'b0);
    msg.push_back(name[23:16]); msg.push_back(name[15:8]); msg.push_back(name[7:0]);
    msg.push_back(SPACE_CHAR);
    name = rnd_name(1'b1);
    msg.push_back(name[23:16]); msg.push_back(name[15:8]); msg.push_back(name[7:0]);
    msg.push_back(SPACE_CHAR);
    msg.push_back(rnd_digit()); msg.push_back(rnd_digit()); msg.push_back(SPACE_CHAR);
    msg.push_back(rnd_digit()); msg.push_back(rnd_digit()); msg.push_back(COLON_CHAR);
    msg.push_back(rnd_digit()); msg.push_back(rnd_digit()); msg.push_back(COLON_CHAR);
    msg.push_back(rnd_digit()); msg.push_back(rnd_digit()); msg.push_back(SPACE_CHAR);
    msg.push_back("2"); msg.push_back("0");
    if ($urandom_range(0, 5) == 0) begin
      msg.push_back("7"); msg.push_back("0");
    end else begin
      msg.push_back(rnd_digit()); msg.push_back(rnd_digit());
    end
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, 25);
        while (msg.size() > cut) void'(msg.pop_back());
        msg.push_back(NEWLINE_CHAR);
      end
      1: begin
        while (msg.size() < BUF_LEN + 4) begin
          b = 8'($urandom_range(0, 255));
          msg.push_back(b == NEWLINE_CHAR ? 8'h0B : b);
        end
      end
      default: msg.push_back(NEWLINE_CHAR);
    endcase
    push_byte(msg[0], drain);
    for (int i = 1; i < msg.size(); i++) push_byte(msg[i]);
  endtask

  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Sender: bursts of requests with random gaps; some requests first wait
  // until every decoded reply has come out.
  always @(posedge clk_i or negedge rst_ni) begin
    logic       next_valid;
    logic [7:0] next_byte;
    result_t    reply;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
    end else begin
      next_valid = in_valid;
      next_byte  = rx_byte;
      if (in_valid && !in_stall_o) begin
        if (take_byte(rx_byte, reply)) pending_replies.push_back(reply);
        bytes_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (byte_plan.size() != 0 &&
                     !(byte_plan[0].drain && pending_replies.size() != 0)) begin
          next_byte  = byte_plan[0].value;
          next_valid = 1'b1;
          void'(byte_plan.pop_front());
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= next_valid;
      rx_byte  <= next_byte;
    end
  end

  // Receiver: checks each decoded reply and stalls in segments of its own.
  always @(posedge clk_i or negedge rst_ni) begin
    logic    next_stall;
    result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("decoded reply with nothing pending");
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          check_field("year_bcd", want.year_bcd, year_bcd_o);
          check_field("month_bcd", 8'(want.month_bcd), 8'(month_bcd_o));
          check_field("date_bcd", want.date_bcd, date_bcd_o);
          check_field("hour_bcd", want.hour_bcd, hour_bcd_o);
          check_field("minute_bcd", want.minute_bcd, minute_bcd_o);
          check_field("second_bcd", want.second_bcd, second_bcd_o);
          check_field("weekday_bcd", 8'(want.weekday_bcd), 8'(weekday_bcd_o));
          check_field("month_found", 8'(want.month_found), 8'(month_found_o));
          check_field("weekday_found", 8'(want.weekday_found), 8'(weekday_found_o));
          check_field("set_clock", 8'(want.set_clock), 8'(set_clock_o));
          replies_seen++;
          weekday_hits += want.weekday_found;
          month_hits   += want.month_found;
          clock_kept   += !want.set_clock;
        end
      end
      // One long hold-off so the block backs up and stalls its input.
      if (replies_seen == 20 && !held_long) begin
        hold_left = HOLD_CYCLES;
        held_long = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end else begin
          seg_left--;
        end
        case (seg_mode)
          STALL_NONE:  next_stall = 1'b0;
          STALL_SOME:  next_stall = ($urandom_range(0, 1) == 0);
          STALL_HEAVY: next_stall = ($urandom_range(0, 4) != 0);
          default:     next_stall = 1'b0;
        endcase
      end
      out_stall <= next_stall;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("ascii_time_reply_to_bcd: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < BUF_LEN; i++) cap_buf[i] = 8'h00;
    cap_pos = 6'd0;

    // Bytes before a colon are ignored, a newline among them too.
    push_byte(8'h00); push_byte(8'hFF); push_byte(NEWLINE_CHAR);
    // Shortest reply: the newline lands in the weekday letters and the rest
    // reads zero, so the empty month pattern matches Dec.
    push_text(":\n");
    push_text(":Mon Jan 01 12:34:56 1970\n");
    // Name fragments cut short by zero bytes.
    push_byte(COLON_CHAR); push_text("T"); push_byte(8'h00); push_byte(8'h00);
    push_byte(SPACE_CHAR); push_text("u"); push_byte(8'h00); push_byte(8'h00);
    push_byte(NEWLINE_CHAR);
    // No newline: the reply closes when the buffer is full.
    push_byte(COLON_CHAR);
    repeat (BUF_LEN - 1) push_byte(8'hFF);

    for (int n = 0; byte_plan.size() < PLAN_BYTES; n++) push_random_reply(n % 8 == 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_plan.size() != 0 || in_valid || pending_replies.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d bytes and %0d decoded replies", bytes_taken, replies_seen);
    $display("weekday hits %0d, month hits %0d, year 70 replies %0d",
             weekday_hits, month_hits, clock_kept);
    if (mismatches == 0) begin
      $display("ascii_time_reply_to_bcd: match");
    end else begin
      $display("ascii_time_reply_to_bcd: mismatch");
    end
    $finish;
  end

endmodule
